// ===== design/kcpsv_pkg.sv =====
// Package for the KCP segment stream validator.
// Holds the header layout constants and the failure reason codes.
// No dependencies.
package kcpsv_pkg;

  // Header layout, counted in bytes from the start of a segment header.
  localparam logic [4:0] ID_LAST_POS  = 5'd3;
  localparam logic [4:0] CMD_POS      = 5'd4;
  localparam logic [4:0] LEN_POS      = 5'd20;
  localparam logic [4:0] HDR_LAST_POS = 5'd23;

  // Legal command byte range.
  localparam logic [7:0] CMD_LOW  = 8'd81;
  localparam logic [7:0] CMD_HIGH = 8'd84;

  // Failure reasons, in the order reported on fail_reason.
  typedef enum logic [2:0] {
    FAIL_OK        = 3'd0,
    FAIL_ZERO_CONV = 3'd1,
    FAIL_MISMATCH  = 3'd2,
    FAIL_COMMAND   = 3'd3,
    FAIL_TRUNCATED = 3'd4
  } fail_reason_t;

endpackage

// ===== design/kcp_segment_stream_validator_unit.sv =====
// Top level of the KCP segment stream validator.
// Walks one datagram a byte at a time and reports one verdict per datagram.
// Depends on kcpsv_pkg.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_ready    | data_byte, last_byte
//   output  | out_valid / out_ready  | frame_valid, fail_reason, conversation_id
//
// One byte is taken per cycle while in_ready is high; the parse state updates at the same edge.
// The verdict for a datagram is registered and appears in the cycle after its last byte transfer.
// The result register frees when taken, so a stalled result stops input only
// while a verdict is still held; non-last bytes never wait on the output.
// Reset is synchronous and returns the parser to the start of a datagram.
module kcp_segment_stream_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic [2:0]  fail_reason,
  output logic [31:0] conversation_id
);

  // Parse state.
  logic [4:0]             header_pos;
  logic                   in_payload;
  logic [31:0]            payload_left;
  logic [31:0]            first_conversation;
  logic [31:0]            segment_word;
  logic                   first_segment;
  kcpsv_pkg::fail_reason_t fail_latch;

  logic [4:0]             header_pos_next;
  logic                   in_payload_next;
  logic [31:0]            payload_left_next;
  logic [31:0]            first_conversation_next;
  logic [31:0]            segment_word_next;
  logic                   first_segment_next;
  kcpsv_pkg::fail_reason_t fail_latch_next;
  kcpsv_pkg::fail_reason_t verdict;

  logic [31:0] left_dec;
  logic [31:0] word_base;
  logic [31:0] word_new;
  logic        in_xfer;

  // A held verdict stalls only a last byte, and only if it is not taken this cycle.
  assign in_ready = !out_valid || out_ready || !last_byte;
  assign in_xfer  = in_valid && in_ready;

  // Next parse state for the incoming byte.
  always_comb begin
    header_pos_next         = header_pos;
    in_payload_next         = in_payload;
    payload_left_next       = payload_left;
    first_conversation_next = first_conversation;
    segment_word_next       = segment_word;
    first_segment_next      = first_segment;
    fail_latch_next         = fail_latch;
    left_dec                = payload_left - 32'd1;

    // The word restarts at the first id byte and at the first length byte.
    if (header_pos == 5'd0 || header_pos == kcpsv_pkg::LEN_POS) begin
      word_base = '0;
    end else begin
      word_base = segment_word;
    end
    word_new = word_base | (32'(data_byte) << {header_pos[1:0], 3'b000});

    if (fail_latch == kcpsv_pkg::FAIL_OK) begin
      if (in_payload) begin
        // Skip payload bytes; a new header follows the last one.
        payload_left_next = left_dec;
        if (left_dec == 32'd0) begin
          in_payload_next = 1'b0;
          header_pos_next = 5'd0;
        end
      end else begin
        // Gather the id word and the length word.
        if (header_pos <= kcpsv_pkg::ID_LAST_POS || header_pos >= kcpsv_pkg::LEN_POS) begin
          segment_word_next = word_new;
        end

        // Check the conversation id once all four bytes are in.
        if (header_pos == kcpsv_pkg::ID_LAST_POS) begin
          if (first_segment) begin
            first_conversation_next = word_new;
            first_segment_next      = 1'b0;
            if (word_new == 32'd0) begin
              fail_latch_next = kcpsv_pkg::FAIL_ZERO_CONV;
            end
          end else if (word_new != first_conversation) begin
            fail_latch_next = kcpsv_pkg::FAIL_MISMATCH;
          end
        end

        // Check the command byte.
        if (header_pos == kcpsv_pkg::CMD_POS) begin
          if (data_byte < kcpsv_pkg::CMD_LOW || data_byte > kcpsv_pkg::CMD_HIGH) begin
            fail_latch_next = kcpsv_pkg::FAIL_COMMAND;
          end
        end

        // At the end of the header, enter the payload if it has bytes.
        if (header_pos == kcpsv_pkg::HDR_LAST_POS) begin
          header_pos_next = 5'd0;
          if (word_new != 32'd0) begin
            in_payload_next   = 1'b1;
            payload_left_next = word_new;
          end
        end else begin
          header_pos_next = header_pos + 5'd1;
        end
      end
    end

    // A datagram that stops inside a header or a payload is truncated.
    verdict = fail_latch_next;
    if (fail_latch_next == kcpsv_pkg::FAIL_OK &&
        (in_payload_next || header_pos_next != 5'd0)) begin
      verdict = kcpsv_pkg::FAIL_TRUNCATED;
    end
  end

  // Parse state registers; the last byte returns them to the start state.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos         <= 5'd0;
      in_payload         <= 1'b0;
      payload_left       <= '0;
      first_conversation <= '0;
      segment_word       <= '0;
      first_segment      <= 1'b1;
      fail_latch         <= kcpsv_pkg::FAIL_OK;
    end else if (in_xfer) begin
      if (last_byte) begin
        header_pos         <= 5'd0;
        in_payload         <= 1'b0;
        payload_left       <= '0;
        first_conversation <= '0;
        segment_word       <= '0;
        first_segment      <= 1'b1;
        fail_latch         <= kcpsv_pkg::FAIL_OK;
      end else begin
        header_pos         <= header_pos_next;
        in_payload         <= in_payload_next;
        payload_left       <= payload_left_next;
        first_conversation <= first_conversation_next;
        segment_word       <= segment_word_next;
        first_segment      <= first_segment_next;
        fail_latch         <= fail_latch_next;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with the verdict on the last byte transfer.
  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      frame_valid     <= (verdict == kcpsv_pkg::FAIL_OK);
      fail_reason     <= verdict;
      conversation_id <= first_conversation_next;
    end
  end

endmodule

// ===== design/kcpsv_checker.sv =====
// Port-level checker for the KCP segment stream validator.
// Watches the top level's ports only; bound to the top level below.
// Depends on kcpsv_pkg.
module kcpsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_valid,
  input logic [2:0]  fail_reason,
  input logic [31:0] conversation_id
);

  // The valid flag agrees with the reason code.
  a_valid_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_valid == (fail_reason == kcpsv_pkg::FAIL_OK)))
    else $error("frame_valid disagrees with fail_reason");

  // Only defined reason codes are reported.
  a_reason_defined: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fail_reason == kcpsv_pkg::FAIL_OK ||
                   fail_reason == kcpsv_pkg::FAIL_ZERO_CONV ||
                   fail_reason == kcpsv_pkg::FAIL_MISMATCH ||
                   fail_reason == kcpsv_pkg::FAIL_COMMAND ||
                   fail_reason == kcpsv_pkg::FAIL_TRUNCATED))
    else $error("undefined fail_reason");

  // Every last byte transfer yields a result on the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> out_valid)
    else $error("no result after last byte");

  // A fresh result only follows a last byte transfer.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !($past(out_valid) && !$past(out_ready)) && !$past(rst))
      |-> $past(in_valid && in_ready && last_byte))
    else $error("result without a last byte");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(frame_valid) && $stable(fail_reason) &&
       $stable(conversation_id)))
    else $error("stalled result changed");

endmodule

bind kcp_segment_stream_validator_unit kcpsv_checker u_kcpsv_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_byte       (last_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .frame_valid     (frame_valid),
  .fail_reason     (fail_reason),
  .conversation_id (conversation_id)
);
